// ===== sv/owm_pkg.sv =====
// shared types, constants and the per-phase step function of the one-wire bus master
package owm_pkg;

	localparam int unsigned PRESENCE_SAMPLES = 18;
	localparam int unsigned CHAIN_STEPS = 4;

	localparam logic [4:0] PRES_SAMPLES_W = 5'(PRESENCE_SAMPLES);
	localparam logic [9:0] PRES_GAP = 10'd10;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RST_LOW   = 4'd1;
	localparam logic [3:0] PH_RST_WAIT  = 4'd2;
	localparam logic [3:0] PH_PRES      = 4'd3;
	localparam logic [3:0] PH_PRES_END  = 4'd4;
	localparam logic [3:0] PH_PRES_HOLD = 4'd5;
	localparam logic [3:0] PH_W_LOW     = 4'd6;
	localparam logic [3:0] PH_W_HIGH    = 4'd7;
	localparam logic [3:0] PH_W_REC     = 4'd8;
	localparam logic [3:0] PH_R_LOW     = 4'd9;
	localparam logic [3:0] PH_R_WAIT    = 4'd10;
	localparam logic [3:0] PH_R_TAIL    = 4'd11;
	localparam logic [3:0] PH_S_LOW     = 4'd12;
	localparam logic [3:0] PH_S_WAIT    = 4'd13;
	localparam logic [3:0] PH_S_POLL    = 4'd14;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_RESET = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_WAIT  = 3'd4;

	localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
	localparam logic [2:0] CFG_PRESENCE_DELAY = 3'd1;
	localparam logic [2:0] CFG_WRITE_ONE_LOW  = 3'd2;
	localparam logic [2:0] CFG_WRITE_ONE_HIGH = 3'd3;
	localparam logic [2:0] CFG_WRITE_ZERO_LOW = 3'd4;
	localparam logic [2:0] CFG_READ_SAMPLE    = 3'd5;
	localparam logic [2:0] CFG_READ_TAIL      = 3'd6;
	localparam logic [2:0] CFG_STATUS_SAMPLE  = 3'd7;

	localparam logic [9:0] DEF_RESET_LOW      = 10'd480;
	localparam logic [7:0] DEF_PRESENCE_DELAY = 8'd60;
	localparam logic [7:0] DEF_WRITE_ONE_LOW  = 8'd13;
	localparam logic [7:0] DEF_WRITE_ONE_HIGH = 8'd41;
	localparam logic [7:0] DEF_WRITE_ZERO_LOW = 8'd57;
	localparam logic [7:0] DEF_READ_SAMPLE    = 8'd13;
	localparam logic [7:0] DEF_READ_TAIL      = 8'd41;
	localparam logic [7:0] DEF_STATUS_SAMPLE  = 8'd15;

	typedef struct packed {
		logic [9:0] reset_low;
		logic [7:0] presence_delay;
		logic [7:0] write_one_low;
		logic [7:0] write_one_high;
		logic [7:0] write_zero_low;
		logic [7:0] read_sample;
		logic [7:0] read_tail;
		logic [7:0] status_sample;
	} cfg_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [9:0] slot_timer;
		logic [2:0] bit_index;
		logic [7:0] shift_byte;
		logic [7:0] bytes_left;
		logic [4:0] presence_tries;
		logic       presence_seen;
	} state_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       present;
		logic [7:0] read_value;
		logic       byte_valid;
		logic       last_byte;
	} res_t;

	typedef struct packed {
		state_t st;
		res_t   res;
		logic   stop;
	} step_t;

	function automatic logic owm_drives_low(logic [3:0] phase);
		return (phase == PH_RST_LOW) || (phase == PH_W_LOW) ||
			(phase == PH_R_LOW) || (phase == PH_S_LOW);
	endfunction

	// one pass through the phase sequencer; zero-length phases fall through to the next pass
	function automatic step_t owm_micro_step(step_t s, cfg_t c, logic line);
		step_t      r;
		logic [4:0] tries_n;
		logic [7:0] rshift_n;
		logic [7:0] wshift_n;
		logic [7:0] left_n;
		r = s;
		tries_n = s.st.presence_tries + 5'd1;
		rshift_n = s.st.shift_byte | (8'(line) << s.st.bit_index);
		wshift_n = s.st.shift_byte >> 1;
		left_n = (s.st.bytes_left != 8'd0) ? (s.st.bytes_left - 8'd1) : 8'd0;
		if (!s.stop && (s.st.phase != PH_IDLE)) begin
			if ((s.st.phase == PH_PRES_HOLD) || (s.st.phase == PH_S_POLL)) begin
				if (line) begin
					r.res.present = (s.st.phase == PH_PRES_HOLD);
					r.st.phase = PH_IDLE;
					r.res.done = 1'b1;
				end
				r.stop = 1'b1;
			end else if (s.st.slot_timer != 10'd0) begin
				r.res.drive_low = owm_drives_low(s.st.phase);
				r.st.slot_timer = s.st.slot_timer - 10'd1;
				r.stop = 1'b1;
			end else begin
				case (s.st.phase)
					PH_RST_LOW: begin
						r.st.phase = PH_RST_WAIT;
						r.st.slot_timer = {2'b00, c.presence_delay};
					end
					PH_RST_WAIT: begin
						r.st.phase = PH_PRES;
					end
					PH_PRES: begin
						if (!line) begin
							r.st.presence_seen = 1'b1;
							r.st.phase = PH_PRES_HOLD;
						end else begin
							r.st.presence_tries = tries_n;
							r.st.slot_timer = PRES_GAP;
							if (tries_n >= PRES_SAMPLES_W) begin
								r.st.phase = PH_PRES_END;
							end
						end
					end
					PH_PRES_END: begin
						r.res.present = s.st.presence_seen;
						r.st.phase = PH_IDLE;
						r.res.done = 1'b1;
					end
					PH_W_LOW: begin
						if (s.st.shift_byte[0]) begin
							r.st.phase = PH_W_HIGH;
							r.st.slot_timer = {2'b00, c.write_one_high};
						end else begin
							r.st.phase = PH_W_REC;
							r.st.slot_timer = 10'd1;
						end
					end
					PH_W_HIGH: begin
						r.st.phase = PH_W_REC;
						r.st.slot_timer = 10'd1;
					end
					PH_W_REC: begin
						r.st.shift_byte = wshift_n;
						if (s.st.bit_index == 3'd7) begin
							r.st.bit_index = 3'd0;
							r.st.phase = PH_IDLE;
							r.res.done = 1'b1;
						end else begin
							r.st.bit_index = s.st.bit_index + 3'd1;
							r.st.phase = PH_W_LOW;
							r.st.slot_timer = wshift_n[0] ? {2'b00, c.write_one_low}
								: {2'b00, c.write_zero_low};
						end
					end
					PH_R_LOW: begin
						r.st.phase = PH_R_WAIT;
						r.st.slot_timer = {2'b00, c.read_sample};
					end
					PH_R_WAIT: begin
						r.st.shift_byte = rshift_n;
						if (s.st.bit_index == 3'd7) begin
							r.res.read_value = rshift_n;
							r.res.byte_valid = 1'b1;
							r.st.bytes_left = left_n;
							r.res.last_byte = (left_n == 8'd0);
						end
						r.st.phase = PH_R_TAIL;
						r.st.slot_timer = {2'b00, c.read_tail};
					end
					PH_R_TAIL: begin
						r.st.phase = PH_R_LOW;
						r.st.slot_timer = 10'd1;
						if (s.st.bit_index == 3'd7) begin
							r.st.bit_index = 3'd0;
							r.st.shift_byte = 8'd0;
							if (s.st.bytes_left == 8'd0) begin
								r.st.phase = PH_IDLE;
								r.st.slot_timer = 10'd0;
								r.res.done = 1'b1;
							end
						end else begin
							r.st.bit_index = s.st.bit_index + 3'd1;
						end
					end
					PH_S_LOW: begin
						r.st.phase = PH_S_WAIT;
						r.st.slot_timer = {2'b00, c.status_sample};
					end
					PH_S_WAIT: begin
						r.st.phase = PH_S_POLL;
					end
					default: begin
						r.st.phase = PH_IDLE;
					end
				endcase
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/owm_core.sv =====
// next-state and result logic for one tick of the bus master
module owm_core
	import owm_pkg::*;
(
	input  state_t     cur,
	input  cfg_t       cfg,
	input  logic [2:0] op,
	input  logic [7:0] data_byte,
	input  logic [7:0] read_count,
	input  logic       line_level,
	output state_t     nxt,
	output res_t       res
);

	step_t chain [CHAIN_STEPS+1];

	always_comb begin
		chain[0].st = cur;
		chain[0].res = '0;
		chain[0].stop = 1'b0;
		if (cur.phase == PH_IDLE) begin
			case (op)
				OP_RESET: begin
					chain[0].st.phase = PH_RST_LOW;
					chain[0].st.slot_timer = cfg.reset_low;
					chain[0].st.presence_tries = 5'd0;
					chain[0].st.presence_seen = 1'b0;
				end
				OP_WRITE: begin
					chain[0].st.shift_byte = data_byte;
					chain[0].st.bit_index = 3'd0;
					chain[0].st.phase = PH_W_LOW;
					chain[0].st.slot_timer = data_byte[0] ? {2'b00, cfg.write_one_low}
						: {2'b00, cfg.write_zero_low};
				end
				OP_READ: begin
					if (read_count == 8'd0) begin
						chain[0].res.done = 1'b1;
					end else begin
						chain[0].st.bytes_left = read_count;
						chain[0].st.bit_index = 3'd0;
						chain[0].st.shift_byte = 8'd0;
						chain[0].st.phase = PH_R_LOW;
						chain[0].st.slot_timer = 10'd1;
					end
				end
				OP_WAIT: begin
					chain[0].st.phase = PH_S_LOW;
					chain[0].st.slot_timer = 10'd1;
				end
				default: begin
					chain[0].st = cur;
				end
			endcase
		end
		for (int i = 0; i < CHAIN_STEPS; i++) begin
			chain[i+1] = owm_micro_step(chain[i], cfg, line_level);
		end
		nxt = chain[CHAIN_STEPS].st;
		res = chain[CHAIN_STEPS].res;
		res.busy = (chain[CHAIN_STEPS].st.phase != PH_IDLE);
	end

endmodule

// ===== sv/one_wire_bus_master.sv =====
// one-wire bus master top level: input stage, sequencer state, config registers, result stage
//
// Each transaction on the input channel is one microsecond tick, optionally carrying a
// command (bus reset with presence detect, write byte, read bytes, wait for release) that is
// taken only while the master is idle. One item is accepted every clock cycle unless a held
// result stalls the output, and each item gives exactly one result: it is registered into the
// input register, then passes through the phase sequencer into the result register. The sequencer
// state is updated in the same cycle as its result, so the next item always sees it. Configuration
// registers may be written only while no command is in progress and no item is in flight.
module one_wire_bus_master
	import owm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] data_byte,
	input  logic [7:0] read_count,
	input  logic       line_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       drive_low,
	output logic       busy_res,
	output logic       done_res,
	output logic       present,
	output logic [7:0] read_value,
	output logic       byte_valid,
	output logic       last_byte
);

	logic       valid_s1;
	logic [2:0] op_s1;
	logic [7:0] data_s1;
	logic [7:0] count_s1;
	logic       line_s1;
	logic       out_valid_q;
	res_t       res_s2;
	state_t     state_q;
	state_t     state_nxt;
	res_t       res_nxt;
	cfg_t       cfg_q;
	logic       advance;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			data_s1 <= data_byte;
			count_s1 <= read_count;
			line_s1 <= line_level;
		end
	end

	owm_core u_core (
		.cur        (state_q),
		.cfg        (cfg_q),
		.op         (op_s1),
		.data_byte  (data_s1),
		.read_count (count_s1),
		.line_level (line_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low <= DEF_RESET_LOW;
			cfg_q.presence_delay <= DEF_PRESENCE_DELAY;
			cfg_q.write_one_low <= DEF_WRITE_ONE_LOW;
			cfg_q.write_one_high <= DEF_WRITE_ONE_HIGH;
			cfg_q.write_zero_low <= DEF_WRITE_ZERO_LOW;
			cfg_q.read_sample <= DEF_READ_SAMPLE;
			cfg_q.read_tail <= DEF_READ_TAIL;
			cfg_q.status_sample <= DEF_STATUS_SAMPLE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESET_LOW:      cfg_q.reset_low <= cfg_data;
				CFG_PRESENCE_DELAY: cfg_q.presence_delay <= cfg_data[7:0];
				CFG_WRITE_ONE_LOW:  cfg_q.write_one_low <= cfg_data[7:0];
				CFG_WRITE_ONE_HIGH: cfg_q.write_one_high <= cfg_data[7:0];
				CFG_WRITE_ZERO_LOW: cfg_q.write_zero_low <= cfg_data[7:0];
				CFG_READ_SAMPLE:    cfg_q.read_sample <= cfg_data[7:0];
				CFG_READ_TAIL:      cfg_q.read_tail <= cfg_data[7:0];
				CFG_STATUS_SAMPLE:  cfg_q.status_sample <= cfg_data[7:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = res_s2.drive_low;
	assign busy_res = res_s2.busy;
	assign done_res = res_s2.done;
	assign present = res_s2.present;
	assign read_value = res_s2.read_value;
	assign byte_valid = res_s2.byte_valid;
	assign last_byte = res_s2.last_byte;

	// a finished command leaves the line released and the master idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !drive_low)
		else $error("done reported while busy or driving");

	a_present_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && present |-> done_res)
		else $error("presence reported without done");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> byte_valid)
		else $error("last flag without a completed byte");

	// more bytes to come keeps the read command running
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid && !last_byte |-> busy_res)
		else $error("read ended before the last byte");

endmodule

// ===== sim/owm_result_checker.sv =====
// result checker for the one-wire bus master: tracks the registers, predicts each result, compares
`timescale 1ns / 100ps

module owm_result_checker
	import owm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] op,
	input  logic [7:0] data_byte,
	input  logic [7:0] read_count,
	input  logic       line_level,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       drive_low,
	input  logic       busy_res,
	input  logic       done_res,
	input  logic       present,
	input  logic [7:0] read_value,
	input  logic       byte_valid,
	input  logic       last_byte,
	output int         fail_count,
	output int         outstanding,
	output logic       model_busy,
	output int         checked,
	output int         bytes_read
);

	localparam int REPORT_LIMIT = 40;

	cfg_t       timing;
	logic [3:0] ph;
	logic [9:0] tmr;
	logic [2:0] bit_no;
	logic [7:0] shreg;
	logic [7:0] left;
	logic [4:0] tries;
	logic       seen;
	res_t       expected_q[$];
	res_t       predicted;
	res_t       want;
	res_t       got;
	int         errs;
	int         n_checked;
	int         n_bytes;

	task automatic start_write_bit();
		ph = PH_W_LOW;
		tmr = shreg[0] ? {2'b00, timing.write_one_low} : {2'b00, timing.write_zero_low};
	endtask

	// one microsecond of the bus sequencer, zero-length phases fall through in the same tick
	task automatic advance_tick(input logic [2:0] cmd, input logic [7:0] wbyte,
		input logic [7:0] nbytes, input logic lvl, output res_t r);
		int   guard;
		logic stop;
		r = '0;
		stop = 1'b0;
		if (ph == PH_IDLE) begin
			case (cmd)
				OP_RESET: begin
					ph = PH_RST_LOW;
					tmr = timing.reset_low;
					tries = '0;
					seen = 1'b0;
				end
				OP_WRITE: begin
					shreg = wbyte;
					bit_no = '0;
					start_write_bit();
				end
				OP_READ: begin
					if (nbytes == 8'd0) begin
						r.done = 1'b1;
					end else begin
						left = nbytes;
						bit_no = '0;
						shreg = '0;
						ph = PH_R_LOW;
						tmr = 10'd1;
					end
				end
				OP_WAIT: begin
					ph = PH_S_LOW;
					tmr = 10'd1;
				end
				default: ;
			endcase
		end
		for (guard = 0; guard < 16 && ph != PH_IDLE && !stop; guard++) begin
			if (ph == PH_PRES_HOLD || ph == PH_S_POLL) begin
				if (lvl) begin
					r.present = (ph == PH_PRES_HOLD);
					ph = PH_IDLE;
					r.done = 1'b1;
				end
				stop = 1'b1;
			end else if (tmr != 10'd0) begin
				r.drive_low = (ph == PH_RST_LOW) || (ph == PH_W_LOW) ||
					(ph == PH_R_LOW) || (ph == PH_S_LOW);
				tmr = tmr - 10'd1;
				stop = 1'b1;
			end else begin
				case (ph)
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						tmr = {2'b00, timing.presence_delay};
					end
					PH_RST_WAIT: ph = PH_PRES;
					PH_PRES: begin
						if (!lvl) begin
							seen = 1'b1;
							ph = PH_PRES_HOLD;
						end else begin
							tries = tries + 5'd1;
							tmr = PRES_GAP;
							if (tries >= PRESENCE_SAMPLES) ph = PH_PRES_END;
						end
					end
					PH_PRES_END: begin
						r.present = seen;
						ph = PH_IDLE;
						r.done = 1'b1;
					end
					PH_W_LOW: begin
						if (shreg[0]) begin
							ph = PH_W_HIGH;
							tmr = {2'b00, timing.write_one_high};
						end else begin
							ph = PH_W_REC;
							tmr = 10'd1;
						end
					end
					PH_W_HIGH: begin
						ph = PH_W_REC;
						tmr = 10'd1;
					end
					PH_W_REC: begin
						shreg = shreg >> 1;
						if (bit_no == 3'd7) begin
							bit_no = '0;
							ph = PH_IDLE;
							r.done = 1'b1;
						end else begin
							bit_no = bit_no + 3'd1;
							start_write_bit();
						end
					end
					PH_R_LOW: begin
						ph = PH_R_WAIT;
						tmr = {2'b00, timing.read_sample};
					end
					PH_R_WAIT: begin
						if (lvl) shreg[bit_no] = 1'b1;
						if (bit_no == 3'd7) begin
							r.read_value = shreg;
							r.byte_valid = 1'b1;
							if (left != 8'd0) left = left - 8'd1;
							r.last_byte = (left == 8'd0);
						end
						ph = PH_R_TAIL;
						tmr = {2'b00, timing.read_tail};
					end
					PH_R_TAIL: begin
						if (bit_no == 3'd7) begin
							bit_no = '0;
							shreg = '0;
							if (left == 8'd0) begin
								ph = PH_IDLE;
								r.done = 1'b1;
							end else begin
								ph = PH_R_LOW;
								tmr = 10'd1;
							end
						end else begin
							bit_no = bit_no + 3'd1;
							ph = PH_R_LOW;
							tmr = 10'd1;
						end
					end
					PH_S_LOW: begin
						ph = PH_S_WAIT;
						tmr = {2'b00, timing.status_sample};
					end
					PH_S_WAIT: ph = PH_S_POLL;
					default: ph = PH_IDLE;
				endcase
			end
		end
		r.busy = (ph != PH_IDLE);
	endtask

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			if (errs < REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = '{DEF_RESET_LOW, DEF_PRESENCE_DELAY, DEF_WRITE_ONE_LOW, DEF_WRITE_ONE_HIGH,
				DEF_WRITE_ZERO_LOW, DEF_READ_SAMPLE, DEF_READ_TAIL, DEF_STATUS_SAMPLE};
			ph = PH_IDLE;
			tmr = '0;
			bit_no = '0;
			shreg = '0;
			left = '0;
			tries = '0;
			seen = 1'b0;
			expected_q.delete();
			errs = 0;
			n_checked = 0;
			n_bytes = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RESET_LOW:      timing.reset_low = cfg_data;
					CFG_PRESENCE_DELAY: timing.presence_delay = cfg_data[7:0];
					CFG_WRITE_ONE_LOW:  timing.write_one_low = cfg_data[7:0];
					CFG_WRITE_ONE_HIGH: timing.write_one_high = cfg_data[7:0];
					CFG_WRITE_ZERO_LOW: timing.write_zero_low = cfg_data[7:0];
					CFG_READ_SAMPLE:    timing.read_sample = cfg_data[7:0];
					CFG_READ_TAIL:      timing.read_tail = cfg_data[7:0];
					CFG_STATUS_SAMPLE:  timing.status_sample = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				advance_tick(op, data_byte, read_count, line_level, predicted);
				expected_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				got = {drive_low, busy_res, done_res, present, read_value, byte_valid, last_byte};
				if (expected_q.size() == 0) begin
					if (errs < REPORT_LIMIT)
						$display("%0t: result with no transaction waiting, actual %0h", $time, got);
					errs++;
				end else begin
					want = expected_q.pop_front();
					check_field("drive_low", want.drive_low, got.drive_low);
					check_field("busy_res", want.busy, got.busy);
					check_field("done_res", want.done, got.done);
					check_field("present", want.present, got.present);
					check_field("read_value", want.read_value, got.read_value);
					check_field("byte_valid", want.byte_valid, got.byte_valid);
					check_field("last_byte", want.last_byte, got.last_byte);
					n_checked++;
					if (got.byte_valid) n_bytes++;
				end
			end
		end
		fail_count <= errs;
		outstanding <= expected_q.size();
		model_busy <= (ph != PH_IDLE);
		checked <= n_checked;
		bytes_read <= n_bytes;
	end

endmodule

// ===== sim/tb_top.sv =====
// top of the one-wire bus master testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module tb_top;
	import owm_pkg::*;

	localparam int ITEM_TARGET   = 1850;
	localparam int RANDOM_PHASES = 6;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 96;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int LINE_HIGH     = 0;
	localparam int LINE_NOISY    = 1;
	localparam int LINE_BURSTS   = 2;
	localparam int LINE_HELD_LOW = 3;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_RESET_LOW;
	logic [9:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] op = OP_TICK;
	logic [7:0] data_byte = '0;
	logic [7:0] read_count = '0;
	logic       line_level = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       present;
	logic [7:0] read_value;
	logic       byte_valid;
	logic       last_byte;

	int   fail_count;
	int   outstanding;
	logic model_busy;
	int   checked;
	int   bytes_read;

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_requests = 0;
	int         ticks_sent = 0;
	int         settings_loaded = 1;
	int         cmd_count[8];
	int         low_left = 0;
	int         low_pct = 0;
	int         burst_max = 1;
	logic [9:0] plan[8];

	one_wire_bus_master DUT (.*);

	owm_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver side: random stalls plus one long hold-off at the start of the random phases
	initial begin : receiver
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !arst_n)
				stall = 0;
			else
				stall++;
		end
		$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic next_level();
		if (low_left > 0) begin
			low_left--;
			return 1'b0;
		end
		if (low_pct > 0 && $urandom_range(0, 99) < low_pct) begin
			low_left = $urandom_range(1, burst_max) - 1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic pick_line_style(input int style);
		low_left = 0;
		case (style)
			LINE_NOISY: begin
				low_pct = 50;
				burst_max = 1;
			end
			LINE_BURSTS: begin
				low_pct = 4;
				burst_max = 40;
			end
			LINE_HELD_LOW: begin
				low_pct = 0;
				low_left = $urandom_range(20, 60);
			end
			default: low_pct = 0;
		endcase
	endtask

	task automatic set_idle_mode(input int mode);
		send_idle_pct = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 22 : 0;
		recv_stall_pct <= (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 22 : 0;
	endtask

	task automatic send_tick(input logic [2:0] c, input logic [7:0] d, input logic [7:0] n);
		logic lvl;
		lvl = next_level();
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c;
		data_byte <= d;
		read_count <= n;
		line_level <= lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ticks_sent++;
	endtask

	// keep ticking until the command has run out; noisy fillers throw commands at a busy master
	task automatic finish_command(input logic noisy);
		logic [2:0] filler;
		do begin
			filler = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
			send_tick(filler, 8'($urandom), 8'($urandom));
		end while (model_busy);
	endtask

	task automatic run_command(input logic [2:0] c, input logic [7:0] d, input logic [7:0] n,
		input logic noisy);
		cmd_count[c]++;
		send_tick(c, d, n);
		finish_command(noisy);
	endtask

	task automatic settle();
		pick_line_style(LINE_HIGH);
		finish_command(1'b0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= (3'(i) == CFG_RESET_LOW) ? plan[i] : {2'($urandom), plan[i][7:0]};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	task automatic plan_fixed(input logic [9:0] rst_low, input logic [7:0] slot,
		input logic [7:0] tail);
		plan[CFG_RESET_LOW] = rst_low;
		plan[CFG_PRESENCE_DELAY] = {2'b00, slot};
		plan[CFG_WRITE_ONE_LOW] = {2'b00, slot};
		plan[CFG_WRITE_ONE_HIGH] = {2'b00, slot};
		plan[CFG_WRITE_ZERO_LOW] = {2'b00, slot};
		plan[CFG_READ_SAMPLE] = {2'b00, slot};
		plan[CFG_READ_TAIL] = {2'b00, tail};
		plan[CFG_STATUS_SAMPLE] = {2'b00, slot};
	endtask

	task automatic plan_random();
		plan[CFG_RESET_LOW] = 10'($urandom_range(1, 24));
		plan[CFG_PRESENCE_DELAY] = 10'($urandom_range(1, 12));
		plan[CFG_WRITE_ONE_LOW] = 10'($urandom_range(1, 4));
		plan[CFG_WRITE_ONE_HIGH] = 10'($urandom_range(1, 4));
		plan[CFG_WRITE_ZERO_LOW] = 10'($urandom_range(1, 6));
		plan[CFG_READ_SAMPLE] = 10'($urandom_range(1, 4));
		plan[CFG_READ_TAIL] = 10'($urandom_range(0, 4));
		plan[CFG_STATUS_SAMPLE] = 10'($urandom_range(1, 6));
	endtask

	task automatic random_command(input int phase_no, input int cmd_no);
		logic [2:0] c;
		logic [7:0] n;
		if (phase_no == 0 && cmd_no == 0) hold_requests <= hold_requests + 1;
		if ($urandom_range(0, 99) < 85) begin
			case ($urandom_range(0, 3))
				0:       c = OP_RESET;
				1:       c = OP_WRITE;
				2:       c = OP_READ;
				default: c = OP_WAIT;
			endcase
			n = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
			pick_line_style($urandom_range(LINE_HIGH, LINE_HELD_LOW));
			run_command(c, 8'($urandom), n, $urandom_range(0, 4) == 0);
		end else begin
			pick_line_style(LINE_NOISY);
			repeat ($urandom_range(1, 4))
				send_tick(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
		end
		repeat ($urandom_range(0, 2)) send_tick(OP_TICK, 8'($urandom), 8'($urandom));
	endtask

	initial begin : stimulus
		int phase_start;
		int phase_goal;
		int cmd_no;
		foreach (cmd_count[k]) cmd_count[k] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the timing registers
		set_idle_mode(IDLE_NONE);
		pick_line_style(LINE_NOISY);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_HIGH);
		run_command(OP_WAIT, 8'h00, 8'h00, 1'b0);
		settle();

		// shortest timing: directed corner cases
		plan_fixed(10'd1, 8'd1, 8'd0);
		load_settings();
		pick_line_style(LINE_HIGH);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_HELD_LOW);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_NOISY);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_HIGH);
		run_command(OP_WRITE, 8'h00, 8'h00, 1'b0);
		run_command(OP_WRITE, 8'hFF, 8'h00, 1'b0);
		run_command(OP_WRITE, 8'hA5, 8'h00, 1'b0);
		run_command(OP_READ, 8'h00, 8'd0, 1'b0);
		pick_line_style(LINE_NOISY);
		run_command(OP_READ, 8'h00, 8'd1, 1'b0);
		run_command(OP_READ, 8'h00, 8'd5, 1'b0);
		pick_line_style(LINE_HIGH);
		run_command(OP_WAIT, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_HELD_LOW);
		run_command(OP_WAIT, 8'h00, 8'h00, 1'b0);
		pick_line_style(LINE_HIGH);
		for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
			send_tick(3'(o), 8'hFF, 8'hFF);
		// commands thrown at a busy master are dropped
		send_tick(OP_WRITE, 8'h81, 8'h00);
		send_tick(OP_RESET, 8'h00, 8'h00);
		send_tick(OP_READ, 8'h00, 8'd2);
		send_tick(OP_WAIT, 8'h00, 8'h00);
		finish_command(1'b0);
		settle();

		// longest timing
		plan_fixed(10'd1023, 8'd255, 8'd255);
		load_settings();
		set_idle_mode(IDLE_BOTH);
		pick_line_style(LINE_BURSTS);
		run_command(OP_WAIT, 8'h00, 8'h00, 1'b0);
		settle();

		for (int r = 0; r < RANDOM_PHASES; r++) begin
			plan_random();
			load_settings();
			set_idle_mode(r % 4);
			phase_start = ticks_sent;
			phase_goal = (ITEM_TARGET - ticks_sent) / (RANDOM_PHASES - r);
			cmd_no = 0;
			while (cmd_no == 0 || ticks_sent - phase_start < phase_goal) begin
				random_command(r, cmd_no);
				cmd_no++;
			end
			settle();
		end
		repeat (8) @(posedge clk);

		$display("run covered %0d ticks under %0d timing settings", ticks_sent, settings_loaded);
		$display("%0d resets, %0d writes, %0d reads, %0d waits; %0d results, %0d with read bytes",
			cmd_count[OP_RESET], cmd_count[OP_WRITE], cmd_count[OP_READ], cmd_count[OP_WAIT],
			checked, bytes_read);
		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/owm_pkg.sv
sv/owm_core.sv
sv/one_wire_bus_master.sv
sim/owm_result_checker.sv
sim/tb_top.sv
